[rtl/core/e2e_pkg.sv]
// ----------------------------------------------------------------------------
// e2e_pkg
// Shared types, register indexes and constants of the ECEF to ENU converter.
// ----------------------------------------------------------------------------
`default_nettype none

package e2e_pkg;

    typedef logic signed [34:0] t_coord;
    typedef logic signed [31:0] t_coeff;

    typedef struct packed {
        t_coord [2:0] origin;
        t_coeff [8:0] coeff;
    } t_frame;

    localparam logic [1:0] REG_LATITUDE  = 2'd0;
    localparam logic [1:0] REG_LONGITUDE = 2'd1;
    localparam logic [1:0] REG_HEIGHT    = 2'd2;

    localparam t_coord OUT_MAX = 35'sh3_FFFF_FFFF;
    localparam t_coord OUT_MIN = -35'sh4_0000_0000;

    localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [31:0] ECC_SQ_Q32  = 32'sd28752143;
    localparam logic [63:0]        SEMI_MAJOR  = 64'd6378137000;

    typedef enum logic [4:0] {
        DRV_IDLE,
        DRV_START,
        DRV_CORDIC,
        DRV_SQUARE,
        DRV_ECC,
        DRV_ROOT_INIT,
        DRV_ROOT,
        DRV_DIVIDE,
        DRV_SUM_H,
        DRV_ISSUE_HC,
        DRV_STORE_HC,
        DRV_STORE_NZ,
        DRV_STORE_X,
        DRV_STORE_Y,
        DRV_STORE_Z,
        DRV_STORE_C3,
        DRV_STORE_C4,
        DRV_STORE_C6,
        DRV_STORE_C7
    } t_drv_state;

    function automatic logic signed [33:0] atan_units(input logic [5:0] idx);
        logic signed [33:0] v;
        case (idx)
            6'd0:  v = 34'sh020000000;
            6'd1:  v = 34'sh012E4051E;
            6'd2:  v = 34'sh009FB385B;
            6'd3:  v = 34'sh0051111D4;
            6'd4:  v = 34'sh0028B0D43;
            6'd5:  v = 34'sh00145D7E1;
            6'd6:  v = 34'sh000A2F61E;
            6'd7:  v = 34'sh000517C55;
            6'd8:  v = 34'sh00028BE53;
            6'd9:  v = 34'sh000145F2F;
            6'd10: v = 34'sh0000A2F98;
            6'd11: v = 34'sh0000517CC;
            6'd12: v = 34'sh000028BE6;
            6'd13: v = 34'sh0000145F3;
            6'd14: v = 34'sh00000A2FA;
            6'd15: v = 34'sh00000517D;
            6'd16: v = 34'sh0000028BE;
            6'd17: v = 34'sh00000145F;
            6'd18: v = 34'sh000000A30;
            6'd19: v = 34'sh000000518;
            6'd20: v = 34'sh00000028C;
            6'd21: v = 34'sh000000146;
            6'd22: v = 34'sh0000000A3;
            6'd23: v = 34'sh000000051;
            6'd24: v = 34'sh000000029;
            6'd25: v = 34'sh000000014;
            6'd26: v = 34'sh00000000A;
            6'd27: v = 34'sh000000005;
            6'd28: v = 34'sh000000003;
            6'd29: v = 34'sh000000001;
            6'd30: v = 34'sh000000001;
            default: v = 34'sh000000000;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > ONE_Q30) begin
            r = 32'sh4000_0000;
        end else if (v < -ONE_Q30) begin
            r = -32'sh4000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/e2e_if.sv]
// ----------------------------------------------------------------------------
// e2e_in_if / e2e_out_if
// Valid/ready channels for ECEF points and for ENU results.
// ----------------------------------------------------------------------------
`default_nettype none

interface e2e_in_if;
    logic               valid;
    logic               ready;
    logic signed [34:0] point_x;
    logic signed [34:0] point_y;
    logic signed [34:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

interface e2e_out_if;
    logic               valid;
    logic               ready;
    logic signed [34:0] east;
    logic signed [34:0] north;
    logic signed [34:0] up;
    logic               clipped;

    modport source (output valid, output east, output north, output up,
                    output clipped, input ready);
    modport sink (input valid, input east, input north, input up,
                  input clipped, output ready);
endinterface

`default_nettype wire

[rtl/core/ecef_to_enu_converter.sv]
// ----------------------------------------------------------------------------
// ecef_to_enu_converter
// Throughput is one point per cycle, set by the five-stage point pipeline,
// while the receiver is ready and no derivation runs. After reset and after
// each write to the latitude, longitude or height register the origin and
// matrix are derived by the serial CORDIC, root and divider; no point is
// accepted meanwhile. Reset is synchronous and active low.
// ----------------------------------------------------------------------------
`default_nettype none

module ecef_to_enu_converter import e2e_pkg::*; #(
    parameter int COEFF_FRAC_BITS = 30,
    parameter int CORDIC_STEPS    = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wen,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    e2e_in_if.sink           i_point,
    e2e_out_if.source        o_enu
);

    logic signed [31:0] r_latitude;
    logic signed [31:0] r_longitude;
    logic signed [27:0] r_height;
    logic   w_write;
    logic   w_busy;
    t_frame w_frame;

    assign w_write = i_cfg_wen && ((i_cfg_index == REG_LATITUDE)
                                   || (i_cfg_index == REG_LONGITUDE)
                                   || (i_cfg_index == REG_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latitude  <= '0;
            r_longitude <= '0;
            r_height    <= '0;
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                REG_LATITUDE:  r_latitude  <= i_cfg_data;
                REG_LONGITUDE: r_longitude <= i_cfg_data;
                REG_HEIGHT:    r_height    <= i_cfg_data[27:0];
                default: begin
                end
            endcase
        end
    end

    e2e_derive #(
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS),
        .CORDIC_STEPS    (CORDIC_STEPS)
    ) u_derive (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_write),
        .i_latitude  (r_latitude),
        .i_longitude (r_longitude),
        .i_height    (r_height),
        .o_busy      (w_busy),
        .o_frame     (w_frame)
    );

    e2e_rotate #(
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hold  (w_busy || w_write),
        .i_frame (w_frame),
        .i_point (i_point),
        .o_enu   (o_enu)
    );

    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !i_point.ready)
        else $error("point accepted while the origin is being derived");

    a_write_starts_derive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_write |=> w_busy)
        else $error("register write did not start a derivation");

    a_clip_means_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_enu.valid && o_enu.clipped) |->
            (o_enu.east == OUT_MAX || o_enu.east == OUT_MIN
             || o_enu.north == OUT_MAX || o_enu.north == OUT_MIN
             || o_enu.up == OUT_MAX || o_enu.up == OUT_MIN))
        else $error("clip flag set without a saturated component");

endmodule

`default_nettype wire

[rtl/core/e2e_derive.sv]
// ----------------------------------------------------------------------------
// e2e_derive
// Sequencer that derives the WGS84 origin and the ENU rotation matrix from the
// reference latitude, longitude and height with a shared CORDIC, square root,
// divider and multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module e2e_derive import e2e_pkg::*; #(
    parameter int COEFF_FRAC_BITS = 30,
    parameter int CORDIC_STEPS    = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_latitude,
    input  wire logic signed [31:0] i_longitude,
    input  wire logic signed [27:0] i_height,
    output logic                    o_busy,
    output t_frame                  o_frame
);

    localparam int CF_SH = 30 - COEFF_FRAC_BITS;
    localparam logic signed [31:0] CF_HALF = (CF_SH == 0) ? 32'sd0 : 32'sd1 <<< (CF_SH - 1);
    localparam logic [6:0] CORDIC_LAST = 7'(CORDIC_STEPS - 1);
    localparam logic [6:0] ROOT_LAST   = 7'd31;
    localparam logic [6:0] DIV_LAST    = 7'd63;

    function automatic t_coeff to_coeff(input logic signed [31:0] v);
        logic signed [31:0] s;
        s = v + CF_HALF;
        return s >>> CF_SH;
    endfunction

    t_drv_state r_state, n_state;
    logic [6:0] r_cnt;
    logic       r_phase;
    logic       r_flip;

    logic signed [33:0] r_cx, r_cy, r_cz;
    logic signed [31:0] r_sp, r_cp, r_sl, r_cl;
    logic signed [67:0] r_prod;
    logic [63:0] r_sq_v, r_sq_res, r_sq_bit;
    logic [63:0] r_dv_num;
    logic [31:0] r_dv_rem, r_dv_den;
    logic signed [34:0] r_nrad, r_nh, r_nz;
    t_frame r_frame;

    logic signed [33:0] w_dx, w_dy, w_at, w_nx, w_ny, w_nz;
    logic signed [33:0] w_fx, w_fy;
    logic signed [33:0] w_lat, w_lon;
    logic               w_lon_flip;
    logic signed [35:0] w_mul_a;
    logic signed [31:0] w_mul_b;
    logic signed [67:0] w_rnd, w_ecc_term;
    logic [63:0] w_trial;
    logic        w_sq_ge;
    logic [32:0] w_rem_sh;
    logic        w_dv_ge;
    logic [32:0] w_root_w;

    always_comb begin
        w_dx = r_cy >>> r_cnt[5:0];
        w_dy = r_cx >>> r_cnt[5:0];
        w_at = atan_units(r_cnt[5:0]);
        if (r_cz >= 0) begin
            w_nx = r_cx - w_dx;
            w_ny = r_cy + w_dy;
            w_nz = r_cz - w_at;
        end else begin
            w_nx = r_cx + w_dx;
            w_ny = r_cy - w_dy;
            w_nz = r_cz + w_at;
        end
        w_fx = r_flip ? -w_nx : w_nx;
        w_fy = r_flip ? -w_ny : w_ny;
    end

    always_comb begin
        w_lat = 34'(i_latitude);
        if (w_lat > ONE_Q30) begin
            w_lat = ONE_Q30;
        end else if (w_lat < -ONE_Q30) begin
            w_lat = -ONE_Q30;
        end
        w_lon      = 34'(i_longitude);
        w_lon_flip = 1'b0;
        if (w_lon > ONE_Q30) begin
            w_lon      = w_lon - (ONE_Q30 <<< 1);
            w_lon_flip = 1'b1;
        end else if (w_lon < -ONE_Q30) begin
            w_lon      = w_lon + (ONE_Q30 <<< 1);
            w_lon_flip = 1'b1;
        end
    end

    assign w_trial    = r_sq_res + r_sq_bit;
    assign w_sq_ge    = r_sq_v >= w_trial;
    assign w_rem_sh   = {r_dv_rem, r_dv_num[63]};
    assign w_dv_ge    = w_rem_sh >= {1'b0, r_dv_den};
    assign w_rnd      = (r_prod + 68'sd536870912) >>> 30;
    assign w_ecc_term = (r_prod + 68'sd2147483648) >>> 32;
    assign w_root_w   = 33'h1_0000_0000 - 33'(r_prod[63:30]);

    always_comb begin
        n_state = r_state;
        case (r_state)
            DRV_IDLE:      n_state = DRV_IDLE;
            DRV_START:     n_state = DRV_CORDIC;
            DRV_CORDIC: begin
                if (r_cnt == CORDIC_LAST && r_phase) begin
                    n_state = DRV_SQUARE;
                end
            end
            DRV_SQUARE:    n_state = DRV_ECC;
            DRV_ECC:       n_state = DRV_ROOT_INIT;
            DRV_ROOT_INIT: n_state = DRV_ROOT;
            DRV_ROOT: begin
                if (r_cnt == ROOT_LAST) begin
                    n_state = DRV_DIVIDE;
                end
            end
            DRV_DIVIDE: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = DRV_SUM_H;
                end
            end
            DRV_SUM_H:     n_state = DRV_ISSUE_HC;
            DRV_ISSUE_HC:  n_state = DRV_STORE_HC;
            DRV_STORE_HC:  n_state = DRV_STORE_NZ;
            DRV_STORE_NZ:  n_state = DRV_STORE_X;
            DRV_STORE_X:   n_state = DRV_STORE_Y;
            DRV_STORE_Y:   n_state = DRV_STORE_Z;
            DRV_STORE_Z:   n_state = DRV_STORE_C3;
            DRV_STORE_C3:  n_state = DRV_STORE_C4;
            DRV_STORE_C4:  n_state = DRV_STORE_C6;
            DRV_STORE_C6:  n_state = DRV_STORE_C7;
            DRV_STORE_C7:  n_state = DRV_IDLE;
            default:       n_state = DRV_IDLE;
        endcase
    end

    always_comb begin
        w_mul_a = 36'(r_sp);
        w_mul_b = 32'(r_sp);
        case (r_state)
            DRV_SQUARE: begin
                w_mul_a = 36'(r_sp);
                w_mul_b = 32'(r_sp);
            end
            DRV_ECC: begin
                w_mul_a = $signed({4'b0, r_prod[61:30]});
                w_mul_b = ECC_SQ_Q32;
            end
            DRV_ISSUE_HC: begin
                w_mul_a = 36'(r_nh);
                w_mul_b = 32'(r_cp);
            end
            DRV_STORE_HC: begin
                w_mul_a = 36'(r_nrad);
                w_mul_b = ECC_SQ_Q32;
            end
            DRV_STORE_NZ: begin
                w_mul_a = 36'(r_frame.origin[0]);
                w_mul_b = 32'(r_cl);
            end
            DRV_STORE_X: begin
                w_mul_a = 36'(r_frame.origin[0]);
                w_mul_b = 32'(r_sl);
            end
            DRV_STORE_Y: begin
                w_mul_a = 36'(r_nz);
                w_mul_b = 32'(r_sp);
            end
            DRV_STORE_Z: begin
                w_mul_a = 36'(r_sp);
                w_mul_b = 32'(r_cl);
            end
            DRV_STORE_C3: begin
                w_mul_a = 36'(r_sp);
                w_mul_b = 32'(r_sl);
            end
            DRV_STORE_C4: begin
                w_mul_a = 36'(r_cp);
                w_mul_b = 32'(r_cl);
            end
            DRV_STORE_C6: begin
                w_mul_a = 36'(r_cp);
                w_mul_b = 32'(r_sl);
            end
            default: begin
                w_mul_a = 36'(r_sp);
                w_mul_b = 32'(r_sp);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DRV_START;
        end else if (i_start) begin
            r_state <= DRV_START;
        end else begin
            r_state <= n_state;
        end
    end

    // The hold-center product of the origin is kept in the x origin slot until
    // the x coordinate itself overwrites it.
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        case (r_state)
            DRV_START: begin
                r_cx    <= CORDIC_GAIN;
                r_cy    <= '0;
                r_cz    <= w_lat;
                r_flip  <= 1'b0;
                r_phase <= 1'b0;
                r_cnt   <= '0;
            end
            DRV_CORDIC: begin
                if (r_cnt == CORDIC_LAST) begin
                    if (!r_phase) begin
                        r_cp <= clamp_q30(w_fx);
                        r_sp <= clamp_q30(w_fy);
                    end else begin
                        r_cl <= clamp_q30(w_fx);
                        r_sl <= clamp_q30(w_fy);
                    end
                    r_cx    <= CORDIC_GAIN;
                    r_cy    <= '0;
                    r_cz    <= w_lon;
                    r_flip  <= w_lon_flip;
                    r_phase <= 1'b1;
                    r_cnt   <= '0;
                end else begin
                    r_cx  <= w_nx;
                    r_cy  <= w_ny;
                    r_cz  <= w_nz;
                    r_cnt <= r_cnt + 7'd1;
                end
            end
            DRV_ROOT_INIT: begin
                r_sq_v   <= {3'b0, w_root_w, 28'b0};
                r_sq_res <= '0;
                r_sq_bit <= 64'h4000_0000_0000_0000;
                r_cnt    <= '0;
            end
            DRV_ROOT: begin
                if (w_sq_ge) begin
                    r_sq_v   <= r_sq_v - w_trial;
                    r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                end else begin
                    r_sq_res <= r_sq_res >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
                if (r_cnt == ROOT_LAST) begin
                    r_cnt <= '0;
                end else begin
                    r_cnt <= r_cnt + 7'd1;
                end
            end
            DRV_DIVIDE: begin
                if (r_cnt == 7'd0 && r_dv_den == 32'd0) begin
                    r_dv_den <= 32'd1;
                end
                if (w_dv_ge) begin
                    r_dv_rem <= 32'(w_rem_sh - {1'b0, r_dv_den});
                end else begin
                    r_dv_rem <= w_rem_sh[31:0];
                end
                r_dv_num <= {r_dv_num[62:0], w_dv_ge};
                r_cnt    <= r_cnt + 7'd1;
            end
            DRV_SUM_H: begin
                r_nrad <= $signed(r_dv_num[34:0]);
                r_nh   <= $signed(r_dv_num[34:0]) + 35'(i_height);
            end
            DRV_STORE_HC: begin
                r_frame.origin[0] <= w_rnd[34:0];
            end
            DRV_STORE_NZ: begin
                r_nz <= r_nrad - w_ecc_term[34:0] + 35'(i_height);
            end
            DRV_STORE_X: begin
                r_frame.origin[0] <= w_rnd[34:0];
                r_frame.origin[1] <= r_frame.origin[0];
            end
            DRV_STORE_Y: begin
                r_frame.origin[1] <= w_rnd[34:0];
            end
            DRV_STORE_Z: begin
                r_frame.origin[2] <= w_rnd[34:0];
            end
            DRV_STORE_C3: begin
                r_frame.coeff[3] <= to_coeff(-w_rnd[31:0]);
            end
            DRV_STORE_C4: begin
                r_frame.coeff[4] <= to_coeff(-w_rnd[31:0]);
            end
            DRV_STORE_C6: begin
                r_frame.coeff[6] <= to_coeff(w_rnd[31:0]);
            end
            DRV_STORE_C7: begin
                r_frame.coeff[7] <= to_coeff(w_rnd[31:0]);
                r_frame.coeff[0] <= to_coeff(-32'(r_sl));
                r_frame.coeff[1] <= to_coeff(32'(r_cl));
                r_frame.coeff[2] <= '0;
                r_frame.coeff[5] <= to_coeff(32'(r_cp));
                r_frame.coeff[8] <= to_coeff(32'(r_sp));
            end
            default: begin
            end
        endcase
        if (r_state == DRV_ROOT && r_cnt == ROOT_LAST) begin
            r_dv_num <= (SEMI_MAJOR << 30) + ((w_sq_ge ? ((r_sq_res >> 1) + r_sq_bit)
                                                       : (r_sq_res >> 1)) >> 1);
            r_dv_den <= w_sq_ge ? 32'((r_sq_res >> 1) + r_sq_bit) : 32'(r_sq_res >> 1);
            r_dv_rem <= '0;
        end
    end

    assign o_busy  = (r_state != DRV_IDLE);
    assign o_frame = r_frame;

endmodule

`default_nettype wire

[rtl/core/e2e_rotate.sv]
// ----------------------------------------------------------------------------
// e2e_rotate
// Five-stage point pipeline: input capture, origin subtract, split products,
// partial sums, rounding and saturation into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module e2e_rotate import e2e_pkg::*; #(
    parameter int COEFF_FRAC_BITS = 30
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_hold,
    input  t_frame    i_frame,
    e2e_in_if.sink    i_point,
    e2e_out_if.source o_enu
);

    localparam int F   = COEFF_FRAC_BITS;
    localparam int DW  = 36;
    localparam int QW  = DW - F;
    localparam int HPW = 32 + QW;
    localparam int LPW = 32 + F + 1;
    localparam int HSW = HPW + 2;
    localparam int LSW = LPW + 2;
    localparam int EW  = HSW + F + 1;
    localparam int VW  = EW - F;
    localparam logic signed [EW-1:0] HALF = EW'(1) <<< (F - 1);
    localparam logic signed [VW-1:0] V_MAX = VW'(OUT_MAX);
    localparam logic signed [VW-1:0] V_MIN = VW'(OUT_MIN);

    logic [4:0] r_vld;
    logic [4:0] w_adv;

    t_coord r_pt [3];
    logic signed [DW-1:0]  r_d  [3];
    logic signed [HPW-1:0] r_hp [9];
    logic signed [LPW-1:0] r_lp [9];
    logic signed [HSW-1:0] r_hs [3];
    logic signed [LSW-1:0] r_ls [3];
    t_coord r_res [3];
    logic   r_clip;

    logic signed [HPW-1:0] n_hp [9];
    logic signed [LPW-1:0] n_lp [9];
    logic signed [HSW-1:0] n_hs [3];
    logic signed [LSW-1:0] n_ls [3];
    t_coord n_res [3];
    logic   n_clip;

    assign w_adv[4] = !r_vld[4] || o_enu.ready;
    assign w_adv[3] = !r_vld[3] || w_adv[4];
    assign w_adv[2] = !r_vld[2] || w_adv[3];
    assign w_adv[1] = !r_vld[1] || w_adv[2];
    assign w_adv[0] = !r_vld[0] || w_adv[1];
    assign i_point.ready = w_adv[0] && !i_hold;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                n_hp[k*3+j] = HPW'($signed(i_frame.coeff[k*3+j]) * $signed(r_d[j][DW-1:F]));
                n_lp[k*3+j] = LPW'($signed(i_frame.coeff[k*3+j])
                                   * $signed({1'b0, r_d[j][F-1:0]}));
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_hs[k] = HSW'(r_hp[k*3]) + HSW'(r_hp[k*3+1]) + HSW'(r_hp[k*3+2]);
            n_ls[k] = LSW'(r_lp[k*3]) + LSW'(r_lp[k*3+1]) + LSW'(r_lp[k*3+2]);
        end
    end

    always_comb begin
        logic signed [EW-1:0] exact;
        logic signed [EW-1:0] shifted;
        logic signed [VW-1:0] v;
        n_clip = 1'b0;
        for (int k = 0; k < 3; k++) begin
            exact   = (EW'(r_hs[k]) <<< F) + EW'(r_ls[k]) + HALF;
            shifted = exact >>> F;
            v       = shifted[VW-1:0];
            if (v > V_MAX) begin
                n_res[k] = OUT_MAX;
                n_clip   = 1'b1;
            end else if (v < V_MIN) begin
                n_res[k] = OUT_MIN;
                n_clip   = 1'b1;
            end else begin
                n_res[k] = v[34:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_point.valid && i_point.ready;
            end
            for (int s = 1; s < 5; s++) begin
                if (w_adv[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_pt[0] <= i_point.point_x;
            r_pt[1] <= i_point.point_y;
            r_pt[2] <= i_point.point_z;
        end
        if (w_adv[1]) begin
            for (int j = 0; j < 3; j++) begin
                r_d[j] <= DW'(r_pt[j]) - DW'($signed(i_frame.origin[j]));
            end
        end
        if (w_adv[2]) begin
            r_hp <= n_hp;
            r_lp <= n_lp;
        end
        if (w_adv[3]) begin
            r_hs <= n_hs;
            r_ls <= n_ls;
        end
        if (w_adv[4]) begin
            r_res  <= n_res;
            r_clip <= n_clip;
        end
    end

    assign o_enu.valid   = r_vld[4];
    assign o_enu.east    = r_res[0];
    assign o_enu.north   = r_res[1];
    assign o_enu.up      = r_res[2];
    assign o_enu.clipped = r_clip;

endmodule

`default_nettype wire

[sim/ecef_to_enu_converter_tb.sv]
// ----------------------------------------------------------------------------
// ecef_to_enu_converter_tb
// Streams ECEF points through the converter under several reference origins
// and checks every ENU result against a fixed-point predictor of the WGS84
// origin, the rotation matrix and the per-point product with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module ecef_to_enu_converter_tb import e2e_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COEFF_FRAC = 30;
    localparam int STEPS      = 32;
    localparam longint Q30    = 64'sd1073741824;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        t_coord east;
        t_coord north;
        t_coord up;
        logic   clipped;
    } enu_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wen = 1'b0;
    logic [1:0]  i_cfg_index = REG_LATITUDE;
    logic [31:0] i_cfg_data = '0;

    e2e_in_if  pt_if ();
    e2e_out_if enu_if ();

    ecef_to_enu_converter uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wen  (i_cfg_wen),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_point    (pt_if),
        .o_enu      (enu_if)
    );

    always #5 i_clk = ~i_clk;

    longint lat_reg, lon_reg, hgt_reg;
    longint origin[3];
    longint rot[9];
    enu_t   pending_enu[$];
    int     error_count = 0;
    int     burst_left = 0;
    int     stall_pct = 0;
    int     stall_cnt = 0;

    longint atan_tab[40] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
        64'h00000001, 0, 0, 0, 0, 0, 0, 0, 0, 0};

    function automatic longint qmul(longint a, longint b);
        return (a * b + (Q30 >>> 1)) >>> 30;
    endfunction

    function automatic longint lim_q30(longint v);
        if (v > Q30) return Q30;
        if (v < -Q30) return -Q30;
        return v;
    endfunction

    task automatic cordic_sincos(input longint ang, output longint s, output longint c);
        longint x, y, z, dx, dy;
        bit     flip;
        x = 652032874;
        y = 0;
        z = ang;
        flip = 0;
        if (z > Q30) begin
            z -= 2 * Q30;
            flip = 1;
        end else if (z < -Q30) begin
            z += 2 * Q30;
            flip = 1;
        end
        for (int i = 0; i < STEPS && i < 40; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = lim_q30(x);
        s = lim_q30(y);
    endtask

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint round_coeff(longint q);
        int sh;
        sh = 30 - COEFF_FRAC;
        if (sh == 0) return q;
        return (q + (64'sd1 << (sh - 1))) >>> sh;
    endfunction

    task automatic derive_frame();
        longint lat, sp, cp, sl, cl, nrad, nh, hc, nz;
        longint unsigned s2, t, w, r;
        lat = lim_q30(lat_reg);
        cordic_sincos(lat, sp, cp);
        cordic_sincos(lon_reg, sl, cl);
        s2 = longint'(sp * sp) >> 30;
        t = (64'd28752143 * s2) >> 30;
        w = (64'd1 << 32) - t;
        r = int_sqrt(w << 28);
        if (r == 0) r = 1;
        nrad = longint'(((64'd6378137000 << 30) + (r >> 1)) / r);
        nh = nrad + hgt_reg;
        hc = qmul(nh, cp);
        origin[0] = qmul(hc, cl);
        origin[1] = qmul(hc, sl);
        nz = nrad - longint'((longint'(nrad) * 64'd28752143 + (64'd1 << 31)) >> 32);
        origin[2] = qmul(nz + hgt_reg, sp);
        rot[0] = round_coeff(-sl);
        rot[1] = round_coeff(cl);
        rot[2] = 0;
        rot[3] = round_coeff(-qmul(sp, cl));
        rot[4] = round_coeff(-qmul(sp, sl));
        rot[5] = round_coeff(cp);
        rot[6] = round_coeff(qmul(cp, cl));
        rot[7] = round_coeff(qmul(cp, sl));
        rot[8] = round_coeff(sp);
    endtask

    function automatic enu_t predict_enu(t_coord px, t_coord py, t_coord pz);
        enu_t   res;
        longint d, q[3], rm[3], hi, lo, v;
        t_coord p[3];
        p[0] = px; p[1] = py; p[2] = pz;
        res.clipped = 1'b0;
        for (int j = 0; j < 3; j++) begin
            d = longint'(p[j]) - origin[j];
            q[j] = d >>> COEFF_FRAC;
            rm[j] = d - q[j] * (64'sd1 << COEFF_FRAC);
        end
        for (int k = 0; k < 3; k++) begin
            hi = 0;
            lo = 0;
            for (int j = 0; j < 3; j++) begin
                hi += rot[k * 3 + j] * q[j];
                lo += rot[k * 3 + j] * rm[j];
            end
            v = hi + ((lo + (64'sd1 << (COEFF_FRAC - 1))) >>> COEFF_FRAC);
            if (v > longint'(OUT_MAX)) begin
                v = longint'(OUT_MAX);
                res.clipped = 1'b1;
            end
            if (v < longint'(OUT_MIN)) begin
                v = longint'(OUT_MIN);
                res.clipped = 1'b1;
            end
            if (k == 0) res.east = t_coord'(v);
            else if (k == 1) res.north = t_coord'(v);
            else res.up = t_coord'(v);
        end
        return res;
    endfunction

    // Receiver: ready follows a random stall rate that is redrawn periodically.
    always @(posedge i_clk) begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 64 == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 30;
                2: stall_pct <= 70;
                default: stall_pct <= 95;
            endcase
        end
        enu_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        enu_t exp_r;
        if (i_rst_n && enu_if.valid && enu_if.ready) begin
            if (pending_enu.size() == 0) begin
                $error("unexpected ENU transfer");
                error_count++;
            end else begin
                exp_r = pending_enu.pop_front();
                if (enu_if.east !== exp_r.east) begin
                    $error("east: expected %0d, got %0d", exp_r.east, enu_if.east);
                    error_count++;
                end
                if (enu_if.north !== exp_r.north) begin
                    $error("north: expected %0d, got %0d", exp_r.north, enu_if.north);
                    error_count++;
                end
                if (enu_if.up !== exp_r.up) begin
                    $error("up: expected %0d, got %0d", exp_r.up, enu_if.up);
                    error_count++;
                end
                if (enu_if.clipped !== exp_r.clipped) begin
                    $error("clipped: expected %0b, got %0b", exp_r.clipped,
                           enu_if.clipped);
                    error_count++;
                end
            end
        end
    end

    task automatic send_point(t_coord px, t_coord py, t_coord pz);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                pt_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        pt_if.valid   <= 1'b1;
        pt_if.point_x <= px;
        pt_if.point_y <= py;
        pt_if.point_z <= pz;
        do @(posedge i_clk); while (!pt_if.ready);
        pending_enu.push_back(predict_enu(px, py, pz));
    endtask

    task automatic drain();
        pt_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_enu.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        drain();
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        case (idx)
            REG_LATITUDE:  lat_reg = longint'(signed'(data));
            REG_LONGITUDE: lon_reg = longint'(signed'(data));
            REG_HEIGHT:    hgt_reg = longint'(signed'(data[27:0]));
            default: ;
        endcase
        if (idx != REG_UNUSED) derive_frame();
    endtask

    function automatic longint rand_span(int bits);
        longint v;
        v = {$urandom, $urandom};
        return v >>> (64 - bits);
    endfunction

    task automatic send_near(int bits);
        send_point(t_coord'(origin[0] + rand_span(bits)), t_coord'(origin[1] + rand_span(bits)),
                   t_coord'(origin[2] + rand_span(bits)));
    endtask

    task automatic send_random();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            send_near($urandom_range(4, 28));
        end else if (sel < 9) begin
            send_point(t_coord'({$urandom, $urandom}), t_coord'({$urandom, $urandom}),
                       t_coord'({$urandom, $urandom}));
        end else begin
            send_point($urandom_range(0, 1) ? OUT_MAX : OUT_MIN,
                       $urandom_range(0, 1) ? OUT_MAX : OUT_MIN,
                       $urandom_range(0, 1) ? OUT_MAX : OUT_MIN);
        end
    endtask

    task automatic test_reset_frame();
        send_point(t_coord'(origin[0]), 0, 0);
        send_point(t_coord'(origin[0] + 1000), 2000, -3000);
        send_point(0, 0, 0);
        send_point(OUT_MAX, OUT_MAX, OUT_MAX);
        send_point(OUT_MIN, OUT_MIN, OUT_MIN);
        send_point(OUT_MAX, OUT_MIN, OUT_MAX);
        send_point(OUT_MIN, OUT_MAX, OUT_MIN);
        send_point(t_coord'(origin[0] - 1), -1, 1);
    endtask

    task automatic test_extreme_origins();
        write_reg(REG_LATITUDE, 32'sh4000_0000);
        write_reg(REG_LONGITUDE, 32'sh7FFF_FFFF);
        write_reg(REG_HEIGHT, 32'sd100000000);
        repeat (4) send_near(20);
        send_point(OUT_MIN, OUT_MAX, OUT_MIN);
        write_reg(REG_LATITUDE, -32'sh4000_0000);
        write_reg(REG_LONGITUDE, 32'sh8000_0000);
        write_reg(REG_HEIGHT, -32'sd100000000);
        repeat (4) send_near(20);
        send_point(OUT_MAX, OUT_MIN, OUT_MAX);
        // Latitudes beyond a pole are clamped to the pole.
        write_reg(REG_LATITUDE, 32'sh7FFF_FFFF);
        repeat (3) send_near(16);
        write_reg(REG_LATITUDE, 32'sh8000_0000);
        repeat (3) send_near(16);
        // An unknown register index leaves the frame untouched.
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        repeat (3) send_near(16);
    endtask

    task automatic test_random_origins();
        for (int phase = 0; phase < 8; phase++) begin
            write_reg(REG_LATITUDE, $urandom_range(0, 1) ? $urandom
                      : $urandom_range(0, 32'h7FFF_FFFF) - 32'sh4000_0000);
            write_reg(REG_LONGITUDE, $urandom);
            write_reg(REG_HEIGHT, $urandom_range(0, 200000000) - 100000000);
            repeat (53) send_random();
        end
    endtask

    initial begin
        pt_if.valid   = 1'b0;
        pt_if.point_x = '0;
        pt_if.point_y = '0;
        pt_if.point_z = '0;
        enu_if.ready  = 1'b0;
        lat_reg = 0;
        lon_reg = 0;
        hgt_reg = 0;
        derive_frame();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_frame();
        test_extreme_origins();
        test_random_origins();
        drain();
        if (error_count == 0) begin
            $display("ecef_to_enu_converter_tb: done, clean");
        end else begin
            $display("ecef_to_enu_converter_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("ecef_to_enu_converter_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
